// ===== rtl/clrm_pkg.sv =====
package clrm_pkg;

  localparam int SCALE_FACTOR = 100;

  // quotient of the scaling divide never exceeds SCALE_FACTOR
  localparam int QW = $clog2(SCALE_FACTOR + 1);
  // scaled numerator |sample - in_start| * SCALE_FACTOR
  localparam int NW = $clog2(65535 * SCALE_FACTOR + 1);
  // compare width for the shifted divisor
  localparam int CW = 16 + QW;
  // scaled * |out_end - out_start|
  localparam int PW = $clog2(255 * SCALE_FACTOR + 1);

  // divide by SCALE_FACTOR as multiply by reciprocal, exact for PW-bit operands
  localparam int RSH   = PW + $clog2(SCALE_FACTOR);
  localparam int RECIP = ((1 << RSH) + SCALE_FACTOR - 1) / SCALE_FACTOR;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int MW    = PW + RW;

  // input register, numerator, divide stages, product, reciprocal, output
  localparam int LATENCY = QW + 5;

  localparam logic [2:0] CFG_MODE      = 3'd0;
  localparam logic [2:0] CFG_IN_START  = 3'd1;
  localparam logic [2:0] CFG_IN_END    = 3'd2;
  localparam logic [2:0] CFG_OUT_START = 3'd3;
  localparam logic [2:0] CFG_OUT_END   = 3'd4;

  typedef enum logic [1:0] {
    REGION_INSIDE = 2'd0,
    REGION_START  = 2'd1,
    REGION_END    = 2'd2
  } region_t;

  typedef struct packed {
    logic       use_clamp;
    logic [7:0] base;
    logic       dneg;
    logic [7:0] dmag;
    region_t    region;
  } meta_t;

endpackage

// ===== rtl/clamped_linear_range_map.sv =====
// pipeline: an item accepted at a clock edge passes through the input stage,
// numerator, one divide stage per quotient bit, product, reciprocal multiply
// and output register before it shows on out_*
// throughput: one item per cycle; busy stays low, results cannot be stalled
// reset: pipeline valid bits cleared, registers return to mode 0,
// in 0..1023 mapped onto out 0..255, which mode 0 reads as signed 0..-1
module clamped_linear_range_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_sample,
  output logic        out_valid,
  output logic [7:0]  out_mapped,
  output logic [1:0]  out_region,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int QW = clrm_pkg::QW;
  localparam int NW = clrm_pkg::NW;
  localparam int CW = clrm_pkg::CW;
  localparam int PW = clrm_pkg::PW;
  localparam int MW = clrm_pkg::MW;

  logic        mode_r;
  logic [15:0] in_start_r;
  logic [15:0] in_end_r;
  logic [7:0]  out_start_r;
  logic [7:0]  out_end_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      in_start_r  <= 16'd0;
      in_end_r    <= 16'd1023;
      out_start_r <= 8'd0;
      out_end_r   <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        clrm_pkg::CFG_MODE:      mode_r      <= cfg_data[0];
        clrm_pkg::CFG_IN_START:  in_start_r  <= cfg_data;
        clrm_pkg::CFG_IN_END:    in_end_r    <= cfg_data;
        clrm_pkg::CFG_OUT_START: out_start_r <= cfg_data[7:0];
        clrm_pkg::CFG_OUT_END:   out_end_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: range check and operand setup
  logic [15:0]       s, a, b;
  logic signed [9:0] os, oe, diff;
  logic              rising;
  clrm_pkg::region_t region;
  clrm_pkg::meta_t   meta_nxt;
  logic [15:0]       num_nxt, den_nxt;

  always_comb begin
    s  = mode_r ? {8'h00, in_sample[7:0]}  : in_sample;
    a  = mode_r ? {8'h00, in_start_r[7:0]} : in_start_r;
    b  = mode_r ? {8'h00, in_end_r[7:0]}   : in_end_r;
    os = mode_r ? {2'b00, out_start_r} : {{2{out_start_r[7]}}, out_start_r};
    oe = mode_r ? {2'b00, out_end_r}   : {{2{out_end_r[7]}}, out_end_r};
    diff = oe - os;
    rising = a < b;
    region = clrm_pkg::REGION_INSIDE;
    if (rising) begin
      if (s < a) region = clrm_pkg::REGION_START;
      else if (s > b) region = clrm_pkg::REGION_END;
    end else begin
      if (s > a) region = clrm_pkg::REGION_START;
      else if (s < b) region = clrm_pkg::REGION_END;
    end
    // only meaningful for samples inside the range
    num_nxt = rising ? s - a : a - s;
    den_nxt = rising ? b - a : a - b;
    meta_nxt.region    = region;
    meta_nxt.use_clamp = (region != clrm_pkg::REGION_INSIDE) || (a == b);
    meta_nxt.base      = (region == clrm_pkg::REGION_END) ? out_end_r : out_start_r;
    meta_nxt.dneg      = diff[9];
    meta_nxt.dmag      = diff[9] ? 8'(-diff) : diff[7:0];
  end

  logic            st0_vld_r;
  clrm_pkg::meta_t st0_meta_r;
  logic [15:0]     st0_num_r;
  logic [15:0]     st0_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st0_vld_r <= 1'b0;
    else        st0_vld_r <= start && !busy;
    st0_meta_r <= meta_nxt;
    st0_num_r  <= num_nxt;
    st0_den_r  <= den_nxt;
  end

  // ---------------- stage 1: scaled numerator, then one quotient bit per stage
  logic            dv_vld_r  [0:QW];
  clrm_pkg::meta_t dv_meta_r [0:QW];
  logic [NW-1:0]   dv_rem_r  [0:QW];
  logic [15:0]     dv_den_r  [0:QW];
  logic [QW-1:0]   dv_q_r    [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else        dv_vld_r[0] <= st0_vld_r;
    dv_meta_r[0] <= st0_meta_r;
    dv_rem_r[0]  <= NW'(32'(st0_num_r) * clrm_pkg::SCALE_FACTOR);
    dv_den_r[0]  <= st0_den_r;
    dv_q_r[0]    <= '0;
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [CW-1:0] shd;
    logic          ge;

    always_comb begin
      shd = CW'(dv_den_r[j-1]) << (QW - j);
      ge  = CW'(dv_rem_r[j-1]) >= shd;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[j] <= 1'b0;
      else        dv_vld_r[j] <= dv_vld_r[j-1];
      dv_meta_r[j] <= dv_meta_r[j-1];
      dv_den_r[j]  <= dv_den_r[j-1];
      dv_rem_r[j]  <= ge ? NW'(CW'(dv_rem_r[j-1]) - shd) : dv_rem_r[j-1];
      dv_q_r[j]    <= dv_q_r[j-1] | (QW'(ge) << (QW - j));
    end
  end

  // ---------------- product with output span
  logic            pr_vld_r;
  clrm_pkg::meta_t pr_meta_r;
  logic [PW-1:0]   pr_prod_r;
  logic [QW+7:0]   prod_full;

  assign prod_full = (QW+8)'(dv_q_r[QW]) * (QW+8)'(dv_meta_r[QW].dmag);

  always_ff @(posedge clk) begin
    if (!rst_n) pr_vld_r <= 1'b0;
    else        pr_vld_r <= dv_vld_r[QW];
    pr_meta_r <= dv_meta_r[QW];
    pr_prod_r <= PW'(prod_full);
  end

  // ---------------- divide by the scale through its reciprocal
  logic            rc_vld_r;
  clrm_pkg::meta_t rc_meta_r;
  logic [7:0]      rc_quo_r;
  logic [MW-1:0]   rc_full;

  assign rc_full = MW'(pr_prod_r) * MW'(clrm_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) rc_vld_r <= 1'b0;
    else        rc_vld_r <= pr_vld_r;
    rc_meta_r <= pr_meta_r;
    rc_quo_r  <= 8'(rc_full >> clrm_pkg::RSH);
  end

  // ---------------- offset by out_start, or pick the clamp value
  logic       out_valid_r;
  logic [7:0] out_mapped_r;
  logic [1:0] out_region_r;
  logic [7:0] mapped_nxt;

  always_comb begin
    if (rc_meta_r.use_clamp)
      mapped_nxt = rc_meta_r.base;
    else if (rc_meta_r.dneg)
      mapped_nxt = rc_meta_r.base - rc_quo_r;
    else
      mapped_nxt = rc_meta_r.base + rc_quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= rc_vld_r;
    out_mapped_r <= mapped_nxt;
    out_region_r <= rc_meta_r.region;
  end

  assign out_valid  = out_valid_r;
  assign out_mapped = out_mapped_r;
  assign out_region = out_region_r;

  // ---------------- checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, clrm_pkg::LATENCY))
    else $error("result without an item accepted at the expected time");

  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_region == clrm_pkg::REGION_INSIDE ||
                   out_region == clrm_pkg::REGION_START ||
                   out_region == clrm_pkg::REGION_END))
    else $error("bad region code on output");

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[QW] && !dv_meta_r[QW].use_clamp) |->
      (32'(dv_q_r[QW]) <= clrm_pkg::SCALE_FACTOR))
    else $error("scaled value above the scale factor");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[QW] && !dv_meta_r[QW].use_clamp) |->
      (CW'(dv_rem_r[QW]) < CW'(dv_den_r[QW])))
    else $error("divider remainder not below divisor");

endmodule

// ===== verif/clrm_range_checker.sv =====
module clrm_range_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_sample,
  input  logic        out_valid,
  input  logic [7:0]  out_mapped,
  input  logic [1:0]  out_region,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          err_count,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0]       sample;
    logic [7:0]        mapped;
    clrm_pkg::region_t region;
  } mapping_t;

  mapping_t expected_maps[$];

  logic        mode_r;
  logic [15:0] in_start_r;
  logic [15:0] in_end_r;
  logic [7:0]  out_start_r;
  logic [7:0]  out_end_r;

  initial begin
    err_count    = 0;
    pending      = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count = err_count + 1;
  endtask

  function automatic mapping_t map_sample(input logic [15:0] smp);
    mapping_t m;
    longint   s, a, b, os, oe, scaled, v;
    m.sample = smp;
    m.region = clrm_pkg::REGION_INSIDE;
    if (mode_r) begin
      // 8-bit form: low bytes only, output bytes unsigned
      s  = longint'(smp[7:0]);
      a  = longint'(in_start_r[7:0]);
      b  = longint'(in_end_r[7:0]);
      os = longint'(out_start_r);
      oe = longint'(out_end_r);
    end else begin
      s  = longint'(smp);
      a  = longint'(in_start_r);
      b  = longint'(in_end_r);
      os = longint'($signed(out_start_r));
      oe = longint'($signed(out_end_r));
    end
    if (a < b) begin
      if (s < a) m.region = clrm_pkg::REGION_START;
      else if (s > b) m.region = clrm_pkg::REGION_END;
    end else begin
      if (s > a) m.region = clrm_pkg::REGION_START;
      else if (s < b) m.region = clrm_pkg::REGION_END;
    end
    case (m.region)
      clrm_pkg::REGION_START: v = os;
      clrm_pkg::REGION_END:   v = oe;
      default: begin
        if (a == b) begin
          v = os;
        end else begin
          scaled = ((s - a) * longint'(clrm_pkg::SCALE_FACTOR)) / (b - a);
          v = (scaled * (oe - os)) / longint'(clrm_pkg::SCALE_FACTOR) + os;
        end
      end
    endcase
    m.mapped = v[7:0];
    return m;
  endfunction

  always @(posedge clk) begin
    mapping_t e;
    if (!rst_n) begin
      mode_r      = 1'b0;
      in_start_r  = 16'd0;
      in_end_r    = 16'd1023;
      out_start_r = 8'd0;
      out_end_r   = 8'd255;
      expected_maps.delete();
    end else begin
      if (out_valid) begin
        results_seen = results_seen + 1;
        if (expected_maps.size() == 0) begin
          report_mismatch($sformatf("result mapped=%02h region=%0d with no item outstanding",
                                    out_mapped, out_region));
        end else begin
          e = expected_maps.pop_front();
          if (out_mapped !== e.mapped)
            report_mismatch($sformatf("sample %04h: mapped %02h, want %02h",
                                      e.sample, out_mapped, e.mapped));
          if (out_region !== e.region)
            report_mismatch($sformatf("sample %04h: region %0d, want %0d",
                                      e.sample, out_region, e.region));
        end
      end
      // an item taken at this edge still sees the registers from before it
      if (start && !busy) expected_maps.push_back(map_sample(in_sample));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          clrm_pkg::CFG_MODE:      mode_r      = cfg_data[0];
          clrm_pkg::CFG_IN_START:  in_start_r  = cfg_data;
          clrm_pkg::CFG_IN_END:    in_end_r    = cfg_data;
          clrm_pkg::CFG_OUT_START: out_start_r = cfg_data[7:0];
          clrm_pkg::CFG_OUT_END:   out_end_r   = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    pending = expected_maps.size();
  end

endmodule

// ===== verif/clamped_linear_range_map_tb.sv =====
module clamped_linear_range_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_LAST_INDEX = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_sample = 16'd0;
  logic        out_valid;
  logic [7:0]  out_mapped;
  logic [1:0]  out_region;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  int err_count;
  int pending;
  int results_seen;

  int cycles;
  bit idle_on;
  int n_items;
  int n_narrow;
  int n_settings;
  bit cur_narrow;
  int cur_a;
  int cur_b;

  always #5 clk = ~clk;

  clamped_linear_range_map uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_mapped (out_mapped),
    .out_region (out_region),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  clrm_range_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_mapped   (out_mapped),
    .out_region   (out_region),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .err_count    (err_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [15:0] smp);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start     <= 1'b1;
    in_sample <= smp;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    if (cur_narrow) n_narrow++;
  endtask

  // hold the sender off until every outstanding item has come back
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0:       v = 8'h00;
        1:       v = 8'hFF;
        2:       v = 8'h80;
        default: v = 8'h7F;
      endcase
    end else begin
      v = 8'($urandom);
    end
    return v;
  endfunction

  function automatic logic [15:0] pick_sample();
    int lo, hi, maxv, v;
    maxv = cur_narrow ? 255 : 65535;
    lo = (cur_a < cur_b) ? cur_a : cur_b;
    hi = (cur_a < cur_b) ? cur_b : cur_a;
    case ($urandom_range(0, 9))
      0, 1:          v = $urandom_range(0, maxv);
      2, 3, 4, 5, 6: v = $urandom_range(lo, hi);
      default: begin
        // just around one of the range ends
        v = ($urandom_range(0, 1) ? cur_a : cur_b) + $urandom_range(0, 4) - 2;
        if (v < 0) v = 0;
        if (v > maxv) v = maxv;
      end
    endcase
    if (cur_narrow) return {8'($urandom), 8'(v)};
    return 16'(v);
  endfunction

  task automatic set_random_config;
    int maxv;
    cur_narrow = 1'($urandom_range(0, 1));
    maxv = cur_narrow ? 255 : 65535;
    case ($urandom_range(0, 4))
      0: begin
        cur_a = $urandom_range(0, maxv);
        cur_b = $urandom_range(0, maxv);
      end
      1: begin
        cur_a = $urandom_range(0, maxv - 1);
        cur_b = cur_a + $urandom_range(1, 60);
        if (cur_b > maxv) cur_b = maxv;
      end
      2: begin
        cur_b = $urandom_range(0, maxv - 1);
        cur_a = cur_b + $urandom_range(1, 60);
        if (cur_a > maxv) cur_a = maxv;
      end
      3: begin
        cur_a = $urandom_range(0, maxv);
        cur_b = cur_a;
      end
      default: begin
        cur_a = $urandom_range(0, 1) ? 0 : maxv;
        cur_b = maxv - cur_a;
      end
    endcase
    write_reg(clrm_pkg::CFG_MODE, {15'($urandom), cur_narrow});
    // upper byte is don't-care in 8-bit mode, so fill it with noise
    write_reg(clrm_pkg::CFG_IN_START, cur_narrow ? {8'($urandom), 8'(cur_a)} : 16'(cur_a));
    write_reg(clrm_pkg::CFG_IN_END, cur_narrow ? {8'($urandom), 8'(cur_b)} : 16'(cur_b));
    write_reg(clrm_pkg::CFG_OUT_START, {8'($urandom), pick_byte()});
    write_reg(clrm_pkg::CFG_OUT_END, {8'($urandom), pick_byte()});
    if ($urandom_range(0, 1))
      write_reg(3'($urandom_range(int'(clrm_pkg::CFG_OUT_END) + 1, int'(CFG_LAST_INDEX))),
                16'($urandom));
    n_settings++;
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d items still outstanding", cycles, pending);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    idle_on    = 1'b1;
    n_items    = 0;
    n_narrow   = 0;
    n_settings = 1;
    cur_narrow = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // registers as they come out of reset: 0..1023 onto signed 0..-1
    send_item(16'd0);
    send_item(16'd1023);
    send_item(16'd1024);
    send_item(16'hFFFF);
    send_item(16'd511);
    send_item(16'd1);
    drain();

    // falling input range onto the full signed byte
    write_reg(clrm_pkg::CFG_MODE, 16'hFFFE);
    write_reg(clrm_pkg::CFG_IN_START, 16'd60000);
    write_reg(clrm_pkg::CFG_IN_END, 16'd1000);
    write_reg(clrm_pkg::CFG_OUT_START, 16'h5A80);
    write_reg(clrm_pkg::CFG_OUT_END, 16'hC37F);
    n_settings++;
    send_item(16'd60000);
    send_item(16'd1000);
    send_item(16'hFFFF);
    send_item(16'd0);
    send_item(16'd30000);
    send_item(16'd59999);
    drain();

    // empty range
    write_reg(clrm_pkg::CFG_IN_START, 16'd500);
    write_reg(clrm_pkg::CFG_IN_END, 16'd500);
    write_reg(clrm_pkg::CFG_OUT_START, 16'h0010);
    write_reg(clrm_pkg::CFG_OUT_END, 16'h00F0);
    n_settings++;
    send_item(16'd500);
    send_item(16'd499);
    send_item(16'd501);
    drain();

    // 8-bit form with noise in every upper byte, plus the unused indexes
    write_reg(clrm_pkg::CFG_MODE, 16'hFFFF);
    write_reg(clrm_pkg::CFG_IN_START, 16'hAB10);
    write_reg(clrm_pkg::CFG_IN_END, 16'h12F0);
    write_reg(clrm_pkg::CFG_OUT_START, 16'h3400);
    write_reg(clrm_pkg::CFG_OUT_END, 16'hA5FF);
    for (int i = int'(clrm_pkg::CFG_OUT_END) + 1; i <= int'(CFG_LAST_INDEX); i++)
      write_reg(3'(i), 16'($urandom));
    n_settings++;
    cur_narrow = 1'b1;
    send_item(16'hFF0F);
    send_item(16'h0010);
    send_item(16'h00F0);
    send_item(16'hFFF1);
    send_item(16'h5580);
    send_item(16'h0000);
    send_item(16'hFFFF);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph >= RANDOM_PHASES - 2) idle_on = 1'b0;
      set_random_config();
      repeat (PHASE_ITEMS) send_item(pick_sample());
      drain();
    end

    repeat (clrm_pkg::LATENCY + 8) @(posedge clk);
    $display("summary: %0d items over %0d register settings, %0d in 8-bit mode",
             n_items, n_settings, n_narrow);
    $display("summary: %0d results checked across rising, falling and empty ranges",
             results_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
